/* design/ctd_pkg.sv */
`timescale 1ns / 1ps
// types and constants shared by the chunked transfer decoder
// no dependencies

package ctd_pkg;

	// width of the size accumulator and of the chunk length
	localparam int SIZE_W = 32;

	// character codes
	localparam logic [7:0] CH_HT      = 8'h09;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] CH_BELOW_0 = 8'h2F;
	localparam logic [7:0] CH_ABOVE_9 = 8'h3A;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_UC_A    = 8'h41;
	localparam logic [7:0] CH_UC_F    = 8'h46;
	localparam logic [7:0] CH_LC_A    = 8'h61;
	localparam logic [7:0] CH_LC_F    = 8'h66;

	// result kinds
	typedef enum logic [1:0] {
		KIND_DATA  = 2'd0,
		KIND_HDR   = 2'd1,
		KIND_END   = 2'd2,
		KIND_ERROR = 2'd3
	} kind_t;

	// decoder phases
	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_DIGITS = 3'd1,
		PH_EXT    = 3'd2,
		PH_CR     = 3'd3,
		PH_DATA   = 3'd4
	} phase_t;

	// classified word as it travels through the queue
	typedef struct packed {
		logic [7:0] data;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_fold;
		logic       is_cr;
		logic       is_lf;
	} item_t;

endpackage

/* design/ctd_front.sv */
`timescale 1ns / 1ps
// front end: classifies each incoming word and holds it in a two entry queue
// depends on ctd_pkg

module ctd_front
	import ctd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] in_byte,
	output logic       q_valid,
	output item_t      q_item,
	input  logic       q_pop
);

	item_t      cls;
	item_t      mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;

	// character classification
	always_comb begin
		cls         = '0;
		cls.data    = in_byte;
		cls.is_fold = (in_byte == CH_SP) || (in_byte == CH_HT) ||
			(in_byte == CH_CR) || (in_byte == CH_LF);
		cls.is_cr   = (in_byte == CH_CR);
		cls.is_lf   = (in_byte == CH_LF);
		if (in_byte > CH_BELOW_0 && in_byte < CH_ABOVE_9) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(in_byte - CH_0);
		end else if (in_byte >= CH_LC_A && in_byte <= CH_LC_F) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(in_byte - CH_LC_A + 8'd10);
		end else if (in_byte >= CH_UC_A && in_byte <= CH_UC_F) begin
			cls.is_hex  = 1'b1;
			cls.hex_val = 4'(in_byte - CH_UC_A + 8'd10);
		end
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign q_valid    = (count_q != 2'd0);
	assign q_item     = mem_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/ctd_back.sv */
`timescale 1ns / 1ps
// back end: phase machine, size gathering, payload count and result register
// depends on ctd_pkg

module ctd_back
	import ctd_pkg::*;
#(
	parameter int SIZE_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  item_t             q_item,
	output logic              q_pop,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic [SIZE_W-1:0] chunk_size,
	output logic              last_in_chunk
);

	localparam int CNT_W = $clog2(SIZE_DIGITS + 1);

	phase_t             phase_q, phase_d;
	logic [SIZE_W-1:0]  rem_q, rem_d;
	logic [SIZE_W-1:0]  acc_q, acc_d;
	logic [CNT_W-1:0]   cnt_q, cnt_d;
	logic               ovf_q, ovf_d;
	logic               take;
	logic               line_bad;
	logic               acc_full;
	logic [SIZE_W-1:0]  rem_dec;

	logic               emit;
	kind_t              kind_d;
	logic [7:0]         byte_d;
	logic [SIZE_W-1:0]  size_d;
	logic               last_d;

	logic               res_valid_q;
	kind_t              kind_q;
	logic [7:0]         byte_q;
	logic [SIZE_W-1:0]  size_q;
	logic               last_q;

	// a word is taken whenever the result register can accept
	assign take     = q_valid && (!res_valid_q || !res_stall);
	assign q_pop    = take;
	assign line_bad = (cnt_q == '0) || ovf_q;
	assign acc_full = (cnt_q >= CNT_W'(SIZE_DIGITS)) || (acc_q[SIZE_W-1 -: 4] != 4'd0);
	assign rem_dec  = (rem_q != '0) ? rem_q - SIZE_W'(1) : rem_q;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_DIGITS: begin
				if (!q_item.is_hex) begin
					phase_d = q_item.is_cr ? PH_CR : PH_EXT;
				end
			end
			PH_EXT: begin
				if (q_item.is_cr) begin
					phase_d = PH_CR;
				end
			end
			PH_CR: begin
				if (q_item.is_lf) begin
					phase_d = (line_bad || acc_q == '0) ? PH_SKIP : PH_DATA;
				end else if (!q_item.is_cr) begin
					phase_d = PH_EXT;
				end
			end
			PH_DATA: begin
				if (rem_dec == '0) begin
					phase_d = PH_SKIP;
				end
			end
			default: begin
				if (q_item.is_fold) begin
					phase_d = PH_SKIP;
				end else if (q_item.is_hex) begin
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_EXT;
				end
			end
		endcase
	end

	// datapath updates and result
	always_comb begin
		rem_d  = rem_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		emit   = 1'b0;
		kind_d = KIND_DATA;
		byte_d = 8'd0;
		size_d = '0;
		last_d = 1'b0;
		case (phase_q)
			PH_DIGITS: begin
				if (q_item.is_hex) begin
					if (acc_full) begin
						ovf_d = 1'b1;
					end else begin
						acc_d = {acc_q[SIZE_W-5:0], q_item.hex_val};
						cnt_d = cnt_q + CNT_W'(1);
					end
				end
			end
			PH_EXT: begin
				rem_d = rem_q;
			end
			PH_CR: begin
				if (q_item.is_lf) begin
					emit  = 1'b1;
					acc_d = '0;
					cnt_d = '0;
					ovf_d = 1'b0;
					if (line_bad) begin
						kind_d = KIND_ERROR;
					end else if (acc_q == '0) begin
						kind_d = KIND_END;
					end else begin
						kind_d = KIND_HDR;
						size_d = acc_q;
						rem_d  = acc_q;
					end
				end
			end
			PH_DATA: begin
				emit   = 1'b1;
				kind_d = KIND_DATA;
				byte_d = q_item.data;
				rem_d  = rem_dec;
				last_d = (rem_dec == '0);
			end
			default: begin
				// a non folding word opens a new size line
				if (!q_item.is_fold) begin
					ovf_d = 1'b0;
					if (q_item.is_hex) begin
						acc_d = SIZE_W'(q_item.hex_val);
						cnt_d = CNT_W'(1);
					end else begin
						acc_d = '0;
						cnt_d = '0;
					end
				end
			end
		endcase
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SKIP;
			rem_q   <= '0;
			acc_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			ovf_q   <= ovf_d;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q <= kind_d;
			byte_q <= byte_d;
			size_q <= size_d;
			last_q <= last_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign out_byte      = byte_q;
	assign chunk_size    = size_q;
	assign last_in_chunk = last_q;

endmodule

/* design/chunked_transfer_decoder.sv */
`timescale 1ns / 1ps
// chunked transfer decoder: one word in per cycle, at most one result out
// path: an accepted word passes through the queue, then the result register
// throughput: one word per cycle, held only by result stall or a full two entry queue
// reset: asynchronous, clears queue, phase to skipping, counters and result valid
// depends on ctd_pkg, ctd_front, ctd_back

module chunked_transfer_decoder
	import ctd_pkg::*;
#(
	parameter int SIZE_DIGITS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [7:0]        in_byte,
	output logic              res_valid,
	input  logic              res_stall,
	output logic [1:0]        kind,
	output logic [7:0]        out_byte,
	output logic [SIZE_W-1:0] chunk_size,
	output logic              last_in_chunk
);

	logic  q_valid;
	item_t q_item;
	logic  q_pop;

	// classifier and queue
	ctd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.in_byte    (in_byte),
		.q_valid    (q_valid),
		.q_item     (q_item),
		.q_pop      (q_pop)
	);

	// phase machine and result register
	ctd_back #(
		.SIZE_DIGITS (SIZE_DIGITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.out_byte      (out_byte),
		.chunk_size    (chunk_size),
		.last_in_chunk (last_in_chunk)
	);

	// a full queue always has a word to offer the back end
	a_stall_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> q_valid)
		else $error("input stalled with empty queue head");

	// a chunk header never announces an empty chunk
	a_hdr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind == KIND_HDR) |-> (chunk_size != '0))
		else $error("chunk header with zero size");

	// non payload results carry no byte and no last mark
	a_nonpayload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != KIND_DATA) |-> (out_byte == 8'd0 && !last_in_chunk))
		else $error("non payload result with byte or last mark");

	// only headers carry a size
	a_size_only_hdr: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && kind != KIND_HDR) |-> (chunk_size == '0))
		else $error("size on a result that is not a header");

endmodule

/* sim/tb_chunked_transfer_decoder.sv */
`timescale 1ns / 1ps
// testbench for the chunked transfer decoder: directed table, then random chunk streams
// results checked against typed rows or model; depends on ctd_pkg, chunked_transfer_decoder

module tb_chunked_transfer_decoder;
	import ctd_pkg::*;

	localparam int SIZE_DIGITS = 8;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_X    = 8'h78;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        ob;
		logic [SIZE_W-1:0] len;
		logic              last;
	} result_t;

	// one stimulus word; typed rows carry their own expectation
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       want;
		result_t    res;
	} word_row_t;

	localparam result_t NO_RES = '{KIND_DATA, 8'h00, 32'd0, 1'b0};

	// directed table: line ends, no-digit line, lone LF, double CR, payload extremes, long size
	localparam word_row_t DIRECTED_TAB [27] = '{
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_CR,      1'b0, 1'b0, NO_RES},
		'{CH_LF,      1'b1, 1'b1, '{KIND_END, 8'h00, 32'd0, 1'b0}},
		'{CH_X,       1'b0, 1'b0, NO_RES},
		'{CH_CR,      1'b0, 1'b0, NO_RES},
		'{CH_LF,      1'b1, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 1'b0}},
		'{CH_HT,      1'b0, 1'b0, NO_RES},
		'{8'h32,      1'b0, 1'b0, NO_RES},
		'{CH_SEMI,    1'b0, 1'b0, NO_RES},
		'{CH_LF,      1'b0, 1'b0, NO_RES},
		'{CH_CR,      1'b0, 1'b0, NO_RES},
		'{CH_CR,      1'b0, 1'b0, NO_RES},
		'{CH_LF,      1'b1, 1'b1, '{KIND_HDR, 8'h00, 32'd2, 1'b0}},
		'{8'h00,      1'b1, 1'b1, '{KIND_DATA, 8'h00, 32'd0, 1'b0}},
		'{8'hFF,      1'b1, 1'b1, '{KIND_DATA, 8'hFF, 32'd0, 1'b1}},
		'{CH_SP,      1'b0, 1'b0, NO_RES},
		'{CH_UC_F,    1'b0, 1'b0, NO_RES},
		'{CH_LC_F,    1'b0, 1'b0, NO_RES},
		'{8'h39,      1'b0, 1'b0, NO_RES},
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_0,       1'b0, 1'b0, NO_RES},
		'{CH_LC_A,    1'b0, 1'b0, NO_RES},
		'{CH_CR,      1'b0, 1'b0, NO_RES},
		'{CH_LF,      1'b1, 1'b1, '{KIND_ERROR, 8'h00, 32'd0, 1'b0}}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [7:0]        in_byte = 8'h00;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic [1:0]        kind;
	logic [7:0]        out_byte;
	logic [SIZE_W-1:0] chunk_size;
	logic              last_in_chunk;

	chunked_transfer_decoder #(.SIZE_DIGITS(SIZE_DIGITS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.in_byte      (in_byte),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.kind         (kind),
		.out_byte     (out_byte),
		.chunk_size   (chunk_size),
		.last_in_chunk(last_in_chunk)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	word_row_t stim_q [$];
	result_t   pending_results [$];
	word_row_t cur_row;
	int        send_idle = 13;
	int        recv_idle = 59;
	int        n_queued = 0;
	int        n_words_in = 0;
	int        n_payload = 0;
	int        n_headers = 0;
	int        n_ends = 0;
	int        n_format_err = 0;
	int        n_fail = 0;
	int        cycles = 0;

	// decoder model state, as after reset
	phase_t            dec_phase = PH_SKIP;
	logic [SIZE_W-1:0] dec_left = '0;
	logic [SIZE_W-1:0] dec_acc = '0;
	logic [4:0]        dec_digits = '0;
	logic              dec_overflow = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
		n_fail++;
	endtask

	task automatic clear_size_line();
		dec_acc = '0;
		dec_digits = '0;
		dec_overflow = 1'b0;
	endtask

	task automatic take_digit(input logic [3:0] d);
		if (dec_digits >= SIZE_DIGITS || dec_acc[SIZE_W-1 -: 4] != 4'd0) begin
			dec_overflow = 1'b1;
		end else begin
			dec_acc = {dec_acc[SIZE_W-5:0], d};
			dec_digits++;
		end
	endtask

	// one input word through the decoder model; got tells whether a result comes out
	task automatic decode_word(input logic [7:0] c, output logic got, output result_t r);
		logic [4:0] d;
		got = 1'b0;
		r = NO_RES;
		if (c > CH_BELOW_0 && c < CH_ABOVE_9)
			d = 5'(c - CH_0);
		else if (c >= CH_LC_A && c <= CH_LC_F)
			d = 5'(c - CH_LC_A + 8'd10);
		else if (c >= CH_UC_A && c <= CH_UC_F)
			d = 5'(c - CH_UC_A + 8'd10);
		else
			d = 5'd16;
		case (dec_phase)
			PH_DIGITS: begin
				if (d < 5'd16)
					take_digit(d[3:0]);
				else
					dec_phase = (c == CH_CR) ? PH_CR : PH_EXT;
			end
			PH_EXT: begin
				if (c == CH_CR)
					dec_phase = PH_CR;
			end
			PH_CR: begin
				if (c == CH_LF) begin
					got = 1'b1;
					if (dec_digits == 0 || dec_overflow) begin
						r.kind = KIND_ERROR;
						dec_phase = PH_SKIP;
					end else if (dec_acc == 0) begin
						r.kind = KIND_END;
						dec_phase = PH_SKIP;
					end else begin
						r.kind = KIND_HDR;
						r.len = dec_acc;
						dec_left = dec_acc;
						dec_phase = PH_DATA;
					end
					clear_size_line();
				end else if (c != CH_CR) begin
					dec_phase = PH_EXT;
				end
			end
			PH_DATA: begin
				got = 1'b1;
				r.ob = c;
				if (dec_left != 0)
					dec_left--;
				if (dec_left == 0) begin
					r.last = 1'b1;
					dec_phase = PH_SKIP;
				end
			end
			default: begin
				// skipping; anything else also behaves as skipping
				if (c == CH_SP || c == CH_HT || c == CH_CR || c == CH_LF) begin
					dec_phase = PH_SKIP;
				end else begin
					clear_size_line();
					if (d < 5'd16) begin
						take_digit(d[3:0]);
						dec_phase = PH_DIGITS;
					end else begin
						dec_phase = PH_EXT;
					end
				end
			end
		endcase
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] d, input logic upper);
		if (d < 4'd10)
			return CH_0 + 8'(d);
		return (upper ? CH_UC_A : CH_LC_A) + 8'(d) - 8'd10;
	endfunction

	task automatic push_plain(input logic [7:0] b);
		stim_q.push_back('{b, 1'b0, 1'b0, NO_RES});
		n_queued++;
	endtask

	// mostly well-formed chunks with random content, plus broken lines and raw noise
	task automatic add_random_stream(input int n_words);
		int goal;
		int pick;
		int len;
		int nd;
		int total;
		logic [7:0] b;
		goal = n_queued + n_words;
		while (n_queued < goal) begin
			pick = $urandom_range(0, 99);
			repeat ($urandom_range(0, 2)) begin
				case ($urandom_range(0, 3))
					0: push_plain(CH_SP);
					1: push_plain(CH_HT);
					2: push_plain(CH_CR);
					default: push_plain(CH_LF);
				endcase
			end
			if (pick < 80) begin
				// well-formed size line, optional extension, payload
				nd = $urandom_range(0, 99);
				if (nd < 8)
					len = 0;
				else if (nd < 90)
					len = $urandom_range(1, 12);
				else
					len = $urandom_range(13, 64);
				nd = (len > 15) ? 2 : 1;
				total = ($urandom_range(0, 4) == 0) ? SIZE_DIGITS : $urandom_range(nd, 3);
				for (int k = total - 1; k >= 0; k--)
					push_plain(hex_char(4'(len >> (4 * k)), 1'($urandom_range(0, 1))));
				if ($urandom_range(0, 3) == 0) begin
					push_plain(CH_SEMI);
					repeat ($urandom_range(0, 4)) begin
						b = 8'($urandom_range(0, 255));
						push_plain((b == CH_CR) ? CH_LF : b);
					end
				end
				if ($urandom_range(0, 7) == 0)
					push_plain(CH_CR);
				push_plain(CH_CR);
				push_plain(CH_LF);
				repeat (len)
					push_plain(8'($urandom_range(0, 255)));
				push_plain(CH_CR);
				push_plain(CH_LF);
			end else if (pick < 87) begin
				// too many digits
				repeat ($urandom_range(SIZE_DIGITS + 1, SIZE_DIGITS + 4))
					push_plain(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
				push_plain(CH_CR);
				push_plain(CH_LF);
			end else if (pick < 94) begin
				// no digit, sometimes with a CR that falls back into the extension
				push_plain(8'($urandom_range(8'h47, 8'h60)));
				if ($urandom_range(0, 1) == 0) begin
					push_plain(CH_CR);
					push_plain(CH_X);
				end
				push_plain(CH_CR);
				push_plain(CH_LF);
			end else begin
				repeat ($urandom_range(1, 4))
					push_plain(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic wait_drained();
		while (stim_q.size() != 0 || item_valid || pending_results.size() != 0)
			@(posedge clk);
	endtask

	// word sender: a held word stays put until taken
	always @(posedge clk) begin
		logic    got;
		result_t r;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && !item_stall) begin
				n_words_in++;
				decode_word(cur_row.b, got, r);
				if (cur_row.typed) begin
					if (cur_row.want)
						pending_results.push_back(cur_row.res);
				end else if (got) begin
					pending_results.push_back(r);
				end
			end
			if (!item_valid || !item_stall) begin
				if (stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					cur_row = stim_q.pop_front();
					item_valid <= 1'b1;
					in_byte <= cur_row.b;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver with random stalls
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_idle);
	end

	// compare each taken result with the oldest expectation
	always @(posedge clk) begin
		result_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected, kind", 32'(kind), 32'd0);
			end else begin
				want = pending_results.pop_front();
				if (kind != want.kind)
					report_mismatch("kind", 32'(kind), 32'(want.kind));
				if (out_byte != want.ob)
					report_mismatch("out_byte", 32'(out_byte), 32'(want.ob));
				if (chunk_size != want.len)
					report_mismatch("chunk_size", chunk_size, want.len);
				if (last_in_chunk != want.last)
					report_mismatch("last_in_chunk", 32'(last_in_chunk), 32'(want.last));
				case (want.kind)
					KIND_DATA: n_payload++;
					KIND_HDR: n_headers++;
					KIND_END: n_ends++;
					default: n_format_err++;
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		foreach (DIRECTED_TAB[i])
			stim_q.push_back(DIRECTED_TAB[i]);
		n_queued = $size(DIRECTED_TAB);
		add_random_stream(160);
		wait_drained();
		send_idle = 59;
		recv_idle = 13;
		add_random_stream(160);
		wait_drained();
		send_idle = 0;
		recv_idle = 0;
		add_random_stream(160);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 32'd0);
		$display("covered %0d words in: %0d payload words, %0d chunk headers, %0d ends,",
			n_words_in, n_payload, n_headers, n_ends);
		$display("%0d format errors, under three sender/receiver stall mixes", n_format_err);
		if (n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
design/ctd_pkg.sv
design/ctd_front.sv
design/ctd_back.sv
design/chunked_transfer_decoder.sv
sim/tb_chunked_transfer_decoder.sv
